FILE: rtl/command_descriptor_validator_macros.svh
// Assertion macros for the command descriptor validator
`ifndef COMMAND_DESCRIPTOR_VALIDATOR_MACROS_SVH
`define COMMAND_DESCRIPTOR_VALIDATOR_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define CDV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define CDV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cdv_pkg.sv
// ----------------------------------------------------------------------------
// cdv_pkg
// Types and constants shared by the command descriptor validator.
// ----------------------------------------------------------------------------
package cdv_pkg;

    localparam int unsigned NUM_WORDS = 30;
    localparam logic [31:0] EMPTY_KERNEL = 32'h514e0007;
    localparam logic [31:0] EMPTY_VOP = 32'd34;
    localparam logic [31:0] PROFILE_A = 32'd3;
    localparam logic [31:0] PROFILE_B = 32'd5;
    localparam logic [4:0] FAULT_NONE = 5'd31;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RESERVED = 3'd1,
        ST_VALIDITY = 3'd2,
        ST_SCRATCH  = 3'd3,
        ST_PERM     = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_WINDOW   = 3'd6,
        ST_ALIAS    = 3'd7
    } status_t;

    // Word indexes
    localparam logic [4:0] W_KERNEL = 5'd0;
    localparam logic [4:0] W_VOP    = 5'd5;
    localparam logic [4:0] W_PROF   = 5'd9;
    localparam logic [4:0] W_SRC0   = 5'd10;
    localparam logic [4:0] W_SRC1   = 5'd11;
    localparam logic [4:0] W_SRC2   = 5'd12;
    localparam logic [4:0] W_DST    = 5'd13;
    localparam logic [4:0] W_SCR    = 5'd14;
    localparam logic [4:0] W_SCRSZ  = 5'd17;
    localparam logic [4:0] W_RSV    = 5'd18;
    localparam logic [4:0] W_B0     = 5'd23;
    localparam logic [4:0] W_S0     = 5'd24;
    localparam logic [4:0] W_PERM   = 5'd25;
    localparam logic [4:0] W_B1     = 5'd26;
    localparam logic [4:0] W_S1     = 5'd27;
    localparam logic [4:0] W_BD     = 5'd28;
    localparam logic [4:0] W_SD     = 5'd29;

    typedef struct packed {
        logic [4:0]  word_number;
        logic [63:0] word_value;
        logic        last_word;
    } request_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] fault_word;
    } result_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_READ,
        SQ_DONE
    } seq_state_t;

    // Control from sequencer to datapath
    typedef struct packed {
        logic       cap;
        logic [4:0] idx;
    } ctl_t;

endpackage

FILE: rtl/cdv_store.sv
// ----------------------------------------------------------------------------
// cdv_store
// Descriptor word memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cdv_store #(
    parameter int unsigned DEPTH = cdv_pkg::NUM_WORDS
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [63:0]                  wr_data,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [63:0]                  rd_data
);
    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: rtl/cdv_checker.sv
// ----------------------------------------------------------------------------
// cdv_checker
// Captures words as they are read back and evaluates the checks.
// ----------------------------------------------------------------------------
module cdv_checker (
    input  logic           clk,
    input  cdv_pkg::ctl_t  ctl,
    input  logic [63:0]    rd_data,
    output logic [2:0]     status,
    output logic [4:0]     fault_word
);
    import cdv_pkg::*;

    logic [63:0] w0_reg, w5_reg, w9_reg, a0_reg, a1_reg, a2_reg, ad_reg;
    logic [63:0] scr_reg, scrsz_reg, rsv_reg, perm_reg;
    logic [63:0] b0_reg, s0_reg, b1_reg, s1_reg, bd_reg, sd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.cap)
        begin
            case (ctl.idx)
                W_KERNEL: w0_reg <= rd_data;
                W_VOP:    w5_reg <= rd_data;
                W_PROF:   w9_reg <= rd_data;
                W_SRC0:   a0_reg <= rd_data;
                W_SRC1:   a1_reg <= rd_data;
                W_SRC2:   a2_reg <= rd_data;
                W_DST:    ad_reg <= rd_data;
                W_SCR:    scr_reg <= rd_data;
                W_SCRSZ:  scrsz_reg <= rd_data;
                W_RSV:    rsv_reg <= rd_data;
                W_B0:     b0_reg <= rd_data;
                W_S0:     s0_reg <= rd_data;
                W_PERM:   perm_reg <= rd_data;
                W_B1:     b1_reg <= rd_data;
                W_S1:     s1_reg <= rd_data;
                W_BD:     bd_reg <= rd_data;
                W_SD:     sd_reg <= rd_data;
                default:  ;
            endcase
        end
    end

    // Window evaluation: 0 pass, 1 overflow, 2 mismatch; hit for alias
    function automatic logic [1:0] chk(input logic [63:0] a, input logic [63:0] b,
                                       input logic [63:0] s, input logic e);
        logic [64:0] sum;
        logic [1:0]  r;
        sum = {1'b0, b} + {1'b0, s};
        r = 2'd0;
        if (sum[64])
            r = 2'd1;
        else if (s == '0)
            r = ((b[2:0] == 3'd0) && ({a[63:3], 3'd0} == b)) ? 2'd0 : 2'd2;
        else if (a < b || a > sum[63:0] || (a == sum[63:0] && !e))
            r = 2'd2;
        return r;
    endfunction

    function automatic logic hit(input logic [63:0] a, input logic [63:0] b,
                                 input logic [63:0] s);
        logic [64:0] sum;
        sum = {1'b0, b} + {1'b0, s};
        if (s == '0)
            return (b[2:0] == 3'd0) && ({a[63:3], 3'd0} == b);
        return !sum[64] && a >= b && a < sum[63:0];
    endfunction

    logic [1:0] p0, p1, pd;
    logic       empty;
    logic [1:0] r0, r1, rd;

    always_comb
    begin
        p0 = perm_reg[3:2];
        p1 = perm_reg[5:4];
        pd = perm_reg[7:6];
        empty = (w0_reg[31:0] == EMPTY_KERNEL) && (w5_reg[63:32] == EMPTY_VOP) &&
                (w9_reg[63:32] == 32'd0) &&
                (w9_reg[31:0] == PROFILE_A || w9_reg[31:0] == PROFILE_B);
        r0 = chk(a0_reg, b0_reg, s0_reg, empty);
        r1 = chk(a1_reg, b1_reg, s1_reg, empty);
        rd = chk(ad_reg, bd_reg, sd_reg, empty);
        status = ST_OK;
        fault_word = FAULT_NONE;
        if (rsv_reg[63:32] != '0)
        begin
            status = ST_RESERVED; fault_word = W_RSV;
        end
        else if (perm_reg[63:8] != '0)
        begin
            status = ST_RESERVED; fault_word = W_PERM;
        end
        else if (perm_reg[1:0] != 2'd3)
        begin
            status = ST_VALIDITY; fault_word = W_PERM;
        end
        else if (scr_reg != '0)
        begin
            status = ST_SCRATCH; fault_word = W_SCR;
        end
        else if (scrsz_reg[63:32] != '0)
        begin
            status = ST_SCRATCH; fault_word = W_SCRSZ;
        end
        else if (p0 != 2'd1 || p1[1] || pd != 2'd2)
        begin
            status = ST_PERM; fault_word = W_PERM;
        end
        else if (p1 == 2'd0 && (a1_reg != '0 || b1_reg != '0 || s1_reg != '0))
        begin
            status = ST_PERM; fault_word = W_SRC1;
        end
        else if (r0 != 2'd0)
        begin
            status = (r0 == 2'd1) ? ST_OVERFLOW : ST_WINDOW; fault_word = W_SRC0;
        end
        else if (r1 != 2'd0)
        begin
            status = (r1 == 2'd1) ? ST_OVERFLOW : ST_WINDOW; fault_word = W_SRC1;
        end
        else if (rd != 2'd0)
        begin
            status = (rd == 2'd1) ? ST_OVERFLOW : ST_WINDOW; fault_word = W_DST;
        end
        else if (a2_reg != '0 && !hit(a2_reg, b0_reg, s0_reg) &&
                 !hit(a2_reg, b1_reg, s1_reg) && !hit(a2_reg, bd_reg, sd_reg))
        begin
            status = ST_ALIAS; fault_word = W_SRC2;
        end
    end
endmodule

FILE: rtl/command_descriptor_validator.sv
// ----------------------------------------------------------------------------
// command_descriptor_validator
// Stores descriptor words and checks the descriptor on the last word.
// ----------------------------------------------------------------------------
// channel   | handshake          | payload
// request   | start / busy       | req (word_number, word_value, last_word)
// result    | done strobe        | res (status, fault_word)
//
// A word that is not last leaves busy low; the next request may follow at once.
// A last word holds busy while all 30 words are read back from the memory, one
// per cycle on its single read port, then the result strobes.
// Reset clears the sequencer only; the memory holds no reset value.
// The receiver cannot stall; done lasts exactly one cycle.
module command_descriptor_validator #(
    parameter int unsigned DEPTH = cdv_pkg::NUM_WORDS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cdv_pkg::request_t req,
    output logic              done,
    output cdv_pkg::result_t  res
);
    import cdv_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    seq_state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          capv_reg;
    logic [AW-1:0] capi_reg;
    logic [63:0]   rd_data;
    logic [2:0]    status;
    logic [4:0]    fault_word;
    logic          wr_en;
    ctl_t          ctl;

    assign wr_en = start && !busy && ({1'b0, req.word_number} < 6'(DEPTH));

    cdv_store #(.DEPTH(DEPTH)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(req.word_number[AW-1:0]),
        .wr_data(req.word_value), .rd_addr(cnt_reg), .rd_data(rd_data)
    );

    assign ctl.cap = capv_reg;
    assign ctl.idx = 5'(capi_reg);

    cdv_checker u_check (
        .clk(clk), .ctl(ctl), .rd_data(rd_data),
        .status(status), .fault_word(fault_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            cnt_reg <= '0;
            capv_reg <= 1'b0;
            capi_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            capv_reg <= (state_reg == SQ_READ);
            capi_reg <= cnt_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            SQ_IDLE:
            begin
                busy = 1'b0;
                cnt_next = '0;
                if (start && req.last_word)
                    state_next = SQ_READ;
            end
            SQ_READ:
            begin
                if (cnt_reg == AW'(DEPTH - 1))
                    state_next = SQ_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            SQ_DONE:
            begin
                if (!capv_reg)
                begin
                    done = 1'b1;
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    assign res.status = status;
    assign res.fault_word = fault_word;
endmodule

FILE: rtl/cdv_assert.sv
// ----------------------------------------------------------------------------
// cdv_assert
// Port-level checks on the command descriptor validator.
// ----------------------------------------------------------------------------
`include "command_descriptor_validator_macros.svh"
module cdv_assert (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input cdv_pkg::request_t req,
    input logic              done,
    input cdv_pkg::result_t  res
);
    import cdv_pkg::*;

    `CDV_ASSERT_NEXT(a_last_busy, clk, rst_n, start && !busy && req.last_word, busy, "last word did not raise busy")
    `CDV_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy && !done, "done not followed by idle")
    `CDV_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy, "done while idle")
    `CDV_ASSERT_IMP(a_ok_fault, clk, rst_n, done && res.status == ST_OK, res.fault_word == FAULT_NONE, "ok with fault word")
endmodule

bind command_descriptor_validator cdv_assert u_cdv_assert (.*);
